@@ src/sha_pkg.sv @@
`timescale 1ns / 1ps
package sha_pkg;
    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_ROUND, ST_FOLD, ST_PAD, ST_EMIT
    } t_state;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [63:0] f_iv(input logic mode, input logic [2:0] idx);
        logic [63:0] r;
        r = 64'd0;
        if (!mode) begin
            case (idx)
                3'd0: r = 64'h6a09e667f3bcc908;
                3'd1: r = 64'hbb67ae8584caa73b;
                3'd2: r = 64'h3c6ef372fe94f82b;
                3'd3: r = 64'ha54ff53a5f1d36f1;
                3'd4: r = 64'h510e527fade682d1;
                3'd5: r = 64'h9b05688c2b3e6c1f;
                3'd6: r = 64'h1f83d9abfb41bd6b;
                default: r = 64'h5be0cd19137e2179;
            endcase
        end else begin
            case (idx)
                3'd0: r = 64'hcbbb9d5dc1059ed8;
                3'd1: r = 64'h629a292a367cd507;
                3'd2: r = 64'h9159015a3070dd17;
                3'd3: r = 64'h152fecd8f70e5939;
                3'd4: r = 64'h67332667ffc00b31;
                3'd5: r = 64'h8eb44a8768581511;
                3'd6: r = 64'hdb0c2e0d64f98fa7;
                default: r = 64'h47b5481dbefa4fa4;
            endcase
        end
        return r;
    endfunction

    function automatic logic [63:0] f_k(input logic [6:0] idx);
        logic [63:0] k;
        case (idx)
            7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
            7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
            7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
            7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
            7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
            default: k = 64'd0;
        endcase
        return k;
    endfunction
endpackage

@@ src/sha_ram.sv @@
`timescale 1ns / 1ps
module sha_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ src/sha512_hash_engine.sv @@
`timescale 1ns / 1ps
// SHA-512 / SHA-384 engine taking one message byte per transaction on the slave side
// (tdata: data_byte [7:0], has_byte [8]; tlast marks the end of the message). Bytes are
// packed into 64-bit words, and each full word is written to a 16-entry block store. While
// idle the engine takes one transaction per cycle. The transaction that completes a
// 128-byte block starts a compression, with tready low throughout: a load step, then 80
// rounds, then a fold step. Each round is split into phases because the schedule store
// has one read port. W[t], W[t+1], W[t+9] and W[t+14] are fetched in turn, and the new
// schedule word is written back with the round. The closing transaction writes one
// padding word per cycle, from the word that holds the pad byte up to word 15, and
// then compresses that block. If the pad byte lands in the last two words, or the closing
// byte completes a block, 16 more padding words and a second compression follow. The
// digest then leaves on the master side as 64-bit words, one per cycle while tready is
// high: eight for SHA-512 and six for SHA-384, with tlast on the final word. The slave
// side stays held until the final word is taken. Writing the mode register reloads the
// initial values and drops any message in progress.
module sha512_hash_engine
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,          // hash_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,         // data_byte [7:0], has_byte [8], zero fill
    input  logic        s_axis_tlast,         // last_item
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,         // digest_word [63:0]
    output logic        m_axis_tlast          // digest_last
);
    t_state      r_state, n_state;
    logic        r_mode;
    logic [63:0] r_cv [8];
    logic [63:0] r_v  [8];
    logic [63:0] r_word;                      // word being packed
    logic [6:0]  r_fill;                      // bytes in block
    logic [63:0] r_bits;
    logic [6:0]  r_round;
    logic [1:0]  r_phase;
    logic [63:0] r_w0, r_w1, r_wsum;
    logic [2:0]  r_idx;
    logic        r_final;                     // compressing the closing block
    logic        r_pad;                       // pad a fresh block after this compression
    logic        r_lenw;                      // length fits in the block being padded

    // schedule store port signals
    logic        s_we;
    logic [3:0]  s_waddr, s_raddr;
    logic [63:0] s_wdata, s_rdata;

    sha_ram #(.WIDTH(64), .DEPTH(16)) u_win (
        .i_clk  (i_clk),
        .i_we   (s_we),
        .i_waddr(s_waddr),
        .i_wdata(s_wdata),
        .i_raddr(s_raddr),
        .o_rdata(s_rdata)
    );

    logic        acc;
    logic        has_byte;
    logic        blk_full;
    logic [63:0] in_word, pad_base, pad_word;
    logic [6:0]  pad_pos;
    logic [3:0]  t;
    logic [63:0] s0, s1, wnew, wcur, big0, big1, chs, mj, t1;
    logic [2:0]  last_idx;

    assign acc      = s_axis_tvalid && s_axis_tready;
    assign has_byte = s_axis_tdata[8];
    assign blk_full = has_byte && (r_fill == 7'd127);
    assign in_word  = r_word | ({56'd0, s_axis_tdata[7:0]} << (6'd56 - {r_fill[2:0], 3'd0}));
    // pad byte goes right after the closing byte, in a fresh word if that one is full
    assign pad_pos  = has_byte ? r_fill + 7'd1 : r_fill;
    assign pad_base = !has_byte ? r_word : ((r_fill[2:0] == 3'd7) ? 64'd0 : in_word);
    assign pad_word = pad_base | ({56'd0, PAD_BYTE} << (6'd56 - {pad_pos[2:0], 3'd0}));
    assign t        = r_round[3:0];
    assign last_idx = r_mode ? 3'd5 : 3'd7;

    always_comb begin
        s0   = {r_w1[0], r_w1[63:1]} ^ {r_w1[7:0], r_w1[63:8]} ^ (r_w1 >> 7);
        s1   = {s_rdata[18:0], s_rdata[63:19]} ^ {s_rdata[60:0], s_rdata[63:61]}
             ^ (s_rdata >> 6);
        wnew = r_wsum + s1;
        wcur = (r_round < 7'd16) ? r_w0 : wnew;
        big1 = {r_v[4][13:0], r_v[4][63:14]} ^ {r_v[4][17:0], r_v[4][63:18]}
             ^ {r_v[4][40:0], r_v[4][63:41]};
        chs  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        big0 = {r_v[0][27:0], r_v[0][63:28]} ^ {r_v[0][33:0], r_v[0][63:34]}
             ^ {r_v[0][38:0], r_v[0][63:39]};
        mj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1   = r_v[7] + big1 + chs + f_k(r_round) + wcur;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (acc && blk_full) begin
                    n_state = ST_LOAD;
                end else if (acc && s_axis_tlast) begin
                    n_state = ST_PAD;
                end
            end
            ST_LOAD:  n_state = ST_ROUND;
            ST_ROUND: begin
                if (r_phase == 2'd3 && r_round == 7'd79) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (r_final) begin
                    n_state = ST_EMIT;
                end else if (r_pad) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PAD: begin
                if (r_fill[6:3] == 4'd15) begin
                    n_state = ST_LOAD;
                end
            end
            ST_EMIT: begin
                if (m_axis_tready && r_idx == last_idx) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        s_we    = 1'b0;
        s_waddr = r_fill[6:3];
        s_wdata = in_word;
        s_raddr = t;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                s_we = s_axis_tvalid && has_byte && r_fill[2:0] == 3'd7;
            end
            ST_LOAD: s_raddr = 4'd0;
            ST_ROUND: begin
                // the last phase already fetches W[t] of the next round
                case (r_phase)
                    2'd0: s_raddr = t + 4'd1;
                    2'd1: s_raddr = t + 4'd9;
                    2'd2: s_raddr = t + 4'd14;
                    default: s_raddr = t + 4'd1;
                endcase
                s_we    = (r_phase == 2'd3) && (r_round >= 7'd16);
                s_waddr = t;
                s_wdata = wnew;
            end
            ST_PAD: begin
                s_we    = 1'b1;
                s_wdata = (r_fill[6:3] == 4'd15 && r_lenw) ? r_bits : r_word;
            end
            ST_EMIT: m_axis_tvalid = 1'b1;
            default: ;
        endcase
    end

    assign m_axis_tdata = r_cv[r_idx];
    assign m_axis_tlast = r_idx == last_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_state <= ST_IDLE;
            r_mode  <= i_rst_n ? i_cfg_wdata : 1'b0;
            r_fill  <= 7'd0;
            r_bits  <= 64'd0;
            r_round <= 7'd0;
            r_phase <= 2'd0;
            r_idx   <= 3'd0;
            r_final <= 1'b0;
            r_pad   <= 1'b0;
            r_lenw  <= 1'b0;
            r_word  <= 64'd0;
            for (int i = 0; i < 8; i++) begin
                r_cv[i] <= f_iv(i_rst_n ? i_cfg_wdata : 1'b0, 3'(i));
            end
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    if (acc) begin
                        if (blk_full) begin
                            // block complete: a closing byte leaves a fresh block to pad
                            r_word <= s_axis_tlast ? {PAD_BYTE, 56'd0} : 64'd0;
                            r_fill <= 7'd0;
                            r_bits <= r_bits + 64'd8;
                            r_pad  <= s_axis_tlast;
                            r_lenw <= 1'b1;
                        end else if (s_axis_tlast) begin
                            r_word <= pad_word;
                            r_fill <= pad_pos;
                            r_lenw <= (pad_pos[6:4] != 3'b111);
                            if (has_byte) begin
                                r_bits <= r_bits + 64'd8;
                            end
                        end else if (has_byte) begin
                            r_word <= (r_fill[2:0] == 3'd7) ? 64'd0 : in_word;
                            r_fill <= r_fill + 7'd1;
                            r_bits <= r_bits + 64'd8;
                        end
                    end
                end
                ST_LOAD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_v[i] <= r_cv[i];
                    end
                    r_phase <= 2'd0;
                    r_round <= 7'd0;
                end
                ST_ROUND: begin
                    r_phase <= r_phase + 2'd1;
                    case (r_phase)
                        2'd0: r_w0 <= s_rdata;
                        2'd1: r_w1 <= s_rdata;
                        2'd2: r_wsum <= r_w0 + s0 + s_rdata;
                        default: begin
                            r_round <= (r_round == 7'd79) ? 7'd0 : r_round + 7'd1;
                            r_v[7] <= r_v[6];
                            r_v[6] <= r_v[5];
                            r_v[5] <= r_v[4];
                            r_v[4] <= r_v[3] + t1;
                            r_v[3] <= r_v[2];
                            r_v[2] <= r_v[1];
                            r_v[1] <= r_v[0];
                            r_v[0] <= t1 + big0 + mj;
                        end
                    endcase
                end
                ST_FOLD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_cv[i] <= r_cv[i] + r_v[i];
                    end
                end
                ST_PAD: begin
                    // flush current word, then zeros; length goes in word 15 if it fits
                    r_word <= 64'd0;
                    if (r_fill[6:3] == 4'd15) begin
                        r_fill  <= 7'd0;
                        r_final <= r_lenw;
                        r_pad   <= !r_lenw;
                        r_lenw  <= 1'b1;
                    end else begin
                        r_fill <= {r_fill[6:3] + 4'd1, 3'd0};
                    end
                end
                ST_EMIT: begin
                    if (m_axis_tready) begin
                        if (r_idx == last_idx) begin
                            r_idx   <= 3'd0;
                            r_fill  <= 7'd0;
                            r_bits  <= 64'd0;
                            r_word  <= 64'd0;
                            r_final <= 1'b0;
                            r_pad   <= 1'b0;
                            for (int i = 0; i < 8; i++) begin
                                r_cv[i] <= f_iv(r_mode, 3'(i));
                            end
                        end else begin
                            r_idx <= r_idx + 3'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    a_emit_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_state == ST_EMIT)) else $error("digest shown outside emit");
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready) else $error("input taken while busy");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n || i_cfg_we)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("digest word dropped while stalled");
endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import sha_pkg::*;

    localparam int IDLE_LIMIT  = 20000;
    localparam int SETTLE_CYC  = 400;   // one block plus fold, with margin
    localparam int TARGET_ITEMS = 160;

    localparam logic [63:0] ROUND_K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
        64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
        64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
        64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
        64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
        64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
        64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
        64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
        64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
        64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
        64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
        64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
        64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
        64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
        64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
        64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
        64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
        64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
        64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
        64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
        64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam logic [63:0] START_HASH [2][8] = '{
        '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
          64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
          64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179},
        '{64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17,
          64'h152fecd8f70e5939, 64'h67332667ffc00b31, 64'h8eb44a8768581511,
          64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4}
    };

    localparam logic MODE_SHA512 = 1'b0;
    localparam logic MODE_SHA384 = 1'b1;

    typedef struct {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last_item;
        logic       wait_drain;   // sender holds this one until all digests are in
    } t_msg_item;

    typedef struct {
        logic [63:0] word;
        logic        last;
    } t_digest_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = 16'd0;     // data_byte [7:0], has_byte [8], zero fill
    logic        s_axis_tlast = 1'b0;      // last_item
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;             // digest_word [63:0]
    logic        m_axis_tlast;             // digest_last

    sha512_hash_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_msg_item    pending_items[$];
    t_digest_beat digest_q[$];
    int           error_count = 0;
    int           digests_seen = 0;
    int           items_queued = 0;

    // digest model state
    logic        hash_mode;
    logic [63:0] chain_hash[8];
    logic [63:0] block_words[16];
    int          block_fill;
    logic [63:0] msg_bit_len;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    task automatic compress_block();
        logic [63:0] w[80];
        logic [63:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int t = 0; t < 80; t++) begin
            if (t < 16) begin
                w[t] = block_words[t];
            end else begin
                s0 = rotr(w[t-15], 1) ^ rotr(w[t-15], 8) ^ (w[t-15] >> 7);
                s1 = rotr(w[t-2], 19) ^ rotr(w[t-2], 61) ^ (w[t-2] >> 6);
                w[t] = w[t-16] + s0 + w[t-7] + s1;
            end
        end
        a = chain_hash[0]; b = chain_hash[1]; c = chain_hash[2]; d = chain_hash[3];
        e = chain_hash[4]; f = chain_hash[5]; g = chain_hash[6]; h = chain_hash[7];
        for (int t = 0; t < 80; t++) begin
            t1 = h + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41)) + ((e & f) ^ (~e & g))
                 + ROUND_K[t] + w[t];
            t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_hash[0] += a; chain_hash[1] += b; chain_hash[2] += c; chain_hash[3] += d;
        chain_hash[4] += e; chain_hash[5] += f; chain_hash[6] += g; chain_hash[7] += h;
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        int wi;
        wi = block_fill / 8;
        if (block_fill % 8 == 0)
            block_words[wi] = 64'd0;
        block_words[wi][(7 - block_fill % 8) * 8 +: 8] = b;
        block_fill++;
        if (block_fill == 128) begin
            compress_block();
            block_fill = 0;
        end
    endtask

    task automatic restart_message();
        for (int i = 0; i < 8; i++)
            chain_hash[i] = START_HASH[hash_mode][i];
        block_fill = 0;
        msg_bit_len = 64'd0;
    endtask

    task automatic digest_item(input t_msg_item it);
        logic [63:0] len;
        int          nwords;
        t_digest_beat beat;
        if (it.has_byte) begin
            absorb_byte(it.data_byte);
            msg_bit_len += 64'd8;
        end
        if (it.last_item) begin
            len = msg_bit_len;
            absorb_byte(PAD_BYTE);
            while (block_fill != 112)
                absorb_byte(8'h00);
            for (int i = 0; i < 8; i++)
                absorb_byte(8'h00);
            for (int i = 0; i < 8; i++)
                absorb_byte(len[(7 - i) * 8 +: 8]);
            nwords = (hash_mode == MODE_SHA384) ? 6 : 8;
            for (int k = 0; k < nwords; k++) begin
                beat.word = chain_hash[k];
                beat.last = (k == nwords - 1);
                digest_q.push_back(beat);
            end
            restart_message();
        end
    endtask

    // sender
    t_msg_item cur_item;
    logic      cur_loaded = 1'b0;
    int        send_gap = 0;
    int        send_calm = 0;

    always @(posedge i_clk) begin
        logic next_valid;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            cur_loaded = 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                digest_item(cur_item);
                cur_loaded = 1'b0;
            end
            if (!cur_loaded && pending_items.size() > 0) begin
                cur_item = pending_items.pop_front();
                cur_loaded = 1'b1;
                if (send_calm > 0) begin
                    send_calm--;
                    send_gap = 0;
                end else begin
                    send_gap = $urandom_range(0, 3);
                    if ($urandom_range(0, 19) == 0)
                        send_calm = $urandom_range(10, 30);
                end
            end
            next_valid = 1'b0;
            if (cur_loaded && !(cur_item.wait_drain && digest_q.size() > 0)) begin
                if (send_gap > 0)
                    send_gap--;
                else
                    next_valid = 1'b1;
            end
            s_axis_tvalid <= next_valid;
            s_axis_tdata  <= {7'd0, cur_item.has_byte, cur_item.data_byte};
            s_axis_tlast  <= cur_item.last_item;
        end
    end

    // receiver
    int recv_wait = 0;
    int recv_calm = 0;

    always @(posedge i_clk) begin
        t_digest_beat want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                digests_seen++;
                if (digest_q.size() == 0) begin
                    $error("unexpected digest word %h", m_axis_tdata);
                    error_count++;
                end else begin
                    want = digest_q.pop_front();
                    if (m_axis_tdata !== want.word) begin
                        $error("digest_word: expected %h, got %h", want.word, m_axis_tdata);
                        error_count++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("digest_last: expected %b, got %b", want.last, m_axis_tlast);
                        error_count++;
                    end
                end
                // long hold-off so the engine backs up onto its input
                if (digests_seen == 40) begin
                    recv_wait = 300;
                end else if (recv_calm > 0) begin
                    recv_calm--;
                    recv_wait = 0;
                end else begin
                    recv_wait = $urandom_range(0, 3);
                    if ($urandom_range(0, 15) == 0)
                        recv_calm = $urandom_range(8, 24);
                end
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("sha512_hash_engine regression: fail");
            $finish;
        end
    end

    task automatic queue_item(input logic [7:0] b, input logic hb, input logic li,
                              input logic wd);
        t_msg_item it;
        it.data_byte = b;
        it.has_byte = hb;
        it.last_item = li;
        it.wait_drain = wd;
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic queue_message(input int len, input logic closed);
        logic sep_close;
        logic wd;
        sep_close = (len == 0) || ($urandom_range(0, 3) == 0);
        wd = ($urandom_range(0, 5) == 0);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 11) == 0)
                queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
            queue_item(8'($urandom_range(0, 255)), 1'b1,
                       closed && !sep_close && (i == len - 1), wd && (i == 0));
        end
        if (closed && sep_close)
            queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, wd && (len == 0));
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || cur_loaded || digest_q.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        hash_mode = m;
        restart_message();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int item_goal);
        int len;
        while (items_queued < item_goal) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(110, 130)
                                              : $urandom_range(0, 12);
            // keep the run near its item budget
            if (len > item_goal - items_queued)
                len = item_goal - items_queued;
            queue_message(len, 1'b1);
        end
    endtask

    initial begin
        hash_mode = MODE_SHA512;
        for (int i = 0; i < 16; i++)
            block_words[i] = 64'd0;
        restart_message();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty message, "abc", ignored items, byte extremes
        queue_item(8'h00, 1'b0, 1'b1, 1'b0);
        queue_item(8'h61, 1'b1, 1'b0, 1'b0);
        queue_item(8'h62, 1'b1, 1'b0, 1'b0);
        queue_item(8'h63, 1'b1, 1'b1, 1'b0);
        queue_item(8'hff, 1'b0, 1'b0, 1'b1);
        queue_item(8'hff, 1'b1, 1'b1, 1'b0);
        queue_item(8'h00, 1'b1, 1'b0, 1'b0);
        queue_item(8'hff, 1'b0, 1'b1, 1'b0);
        wait_drained();

        write_mode(MODE_SHA384);
        queue_item(8'h00, 1'b0, 1'b1, 1'b0);
        queue_item(8'hff, 1'b1, 1'b1, 1'b0);
        // long message: padding spills into a second block, or a full block then padding
        queue_message(int'($urandom_range(120, 128)), 1'b1);
        random_phase(TARGET_ITEMS / 2);
        wait_drained();

        // a message left open is dropped by the mode write
        write_mode(MODE_SHA512);
        queue_message(9, 1'b0);
        wait_drained();
        write_mode(MODE_SHA384);
        queue_message(5, 1'b0);
        wait_drained();
        write_mode(MODE_SHA512);
        random_phase(TARGET_ITEMS);
        wait_drained();

        if (error_count == 0)
            $display("sha512_hash_engine regression: pass");
        else
            $display("sha512_hash_engine regression: fail");
        $finish;
    end
endmodule

@@ filelist.f @@
src/sha_pkg.sv
src/sha_ram.sv
src/sha512_hash_engine.sv
tb/sv/testbench.sv
